### hw/rtl/mstk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types, constants and helpers of the spanning-forest savings block.
// ----------------------------------------------------------------------------
package mstk_pkg;

	localparam int MAX_EDGES_DEF    = 1024;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int VERTEX_W  = 10;
	localparam int IN_WGT_W  = 16;
	localparam int SUM_W     = 26;
	localparam int RANK_W    = 4;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_SK_RD,
		S_SK_CAP,
		S_SJ_RD,
		S_SJ_CMP,
		S_SJ_PUT,
		S_KE_RD,
		S_KE_CAP,
		S_FR_RD,
		S_FR_CHK,
		S_FC_RD,
		S_FC_CHK,
		S_RK_A,
		S_RK_B,
		S_LINK,
		S_EMIT
	} state_t;

	// saturating add of an unsigned addend to a running sum
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
		input logic [31:0] v);
		logic [32:0] t;
		t = {7'b0, s} + {1'b0, v};
		if (t > {7'b0, SUM_MAX}) begin
			return SUM_MAX;
		end
		return t[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/mstk_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mstk_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/mst_savings_kruskal_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_savings_kruskal_top
// Spanning-forest savings: loads weighted edges, then sorts them and runs
// union-find to report total weight, forest weight and their difference.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_stall) carries one edge per transfer; an edge
//    without last_edge is stored as it is taken, so edges stream back to back
//  - an edge with last_edge set starts the solve; in_stall stays high until
//    the result has been moved into the output register
//  - solve steps: initialize the parent and rank memories, then an insertion
//    sort of the stored edges, then per edge a find of each endpoint with
//    path compression and, for a kept edge, a rank read and a link, then
//    load the output register; everything is bounded by the single read
//    port of each memory
//  - output channel (out_valid/out_stall) holds one result in a register;
//    while it is stalled, new edges are still taken, and a following solve
//    waits at its end until the register is free
//  - edges with an endpoint at or above MAX_VERTICES, or arriving with the
//    store full, are dropped but their last_edge mark still counts
//  - reset clears the edge count, sums and output valid; the memories are
//    not cleared (parent and rank are rewritten at each solve start)
// ----------------------------------------------------------------------------
module mst_savings_kruskal_top
	import mstk_pkg::*;
#(
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [VERTEX_W-1:0] vertex_a,
	input  wire logic [VERTEX_W-1:0] vertex_b,
	input  wire logic [IN_WGT_W-1:0] weight,
	input  wire logic                last_edge,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [SUM_W-1:0]    savings,
	output logic      [SUM_W-1:0]    forest_weight,
	output logic      [SUM_W-1:0]    total_weight
);

	localparam int EAW = $clog2(MAX_EDGES);
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int EW  = 2 * VERTEX_W + WEIGHT_BITS;

	function automatic logic [VAW-1:0] vtx_addr(input logic [VERTEX_W-1:0] v);
		logic [VAW+VERTEX_W-1:0] ext;
		ext = {{VAW{1'b0}}, v};
		return ext[VAW-1:0];
	endfunction

	state_t state_q, state_d;

	logic [CW-1:0]          cnt_q, i_q, j_q;
	logic [VAW:0]           init_q;
	logic [SUM_W-1:0]       total_q, tree_q;
	logic [EW-1:0]          key_q;
	logic [VAW-1:0]         r_q, v_q, ra_q, eb_q;
	logic                   which_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [RANK_W-1:0]      rank_a_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       savings_q, forest_q, total_out_q;

	// memory ports
	logic                   edge_we, edge_re;
	logic [EAW-1:0]         edge_waddr, edge_raddr;
	logic [EW-1:0]          edge_wdata, edge_rdata;
	logic                   par_we, par_re;
	logic [VAW-1:0]         par_waddr, par_raddr, par_wdata, par_rdata;
	logic                   rank_we, rank_re;
	logic [VAW-1:0]         rank_waddr, rank_raddr;
	logic [RANK_W-1:0]      rank_wdata, rank_rdata;

	mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
	);

	mstk_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_parent_ram (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.re(par_re), .raddr(par_raddr), .rdata(par_rdata)
	);

	mstk_ram #(.WIDTH(RANK_W), .DEPTH(MAX_VERTICES)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata)
	);

	// incoming edge
	logic [IN_WGT_W+31:0]   w_ext;
	logic [WEIGHT_BITS-1:0] w_in;
	logic                   in_xfer, edge_ok;

	assign w_ext   = {32'b0, weight};
	assign w_in    = w_ext[WEIGHT_BITS-1:0];
	assign in_xfer = in_valid && !in_stall;
	assign edge_ok = (cnt_q < CW'(MAX_EDGES))
		&& ({22'b0, vertex_a} < 32'(MAX_VERTICES))
		&& ({22'b0, vertex_b} < 32'(MAX_VERTICES));

	// fields of the edge word read back
	logic [VERTEX_W-1:0]    rd_a, rd_b;
	logic [WEIGHT_BITS-1:0] rd_w, key_w;

	assign rd_a  = edge_rdata[EW-1 -: VERTEX_W];
	assign rd_b  = edge_rdata[WEIGHT_BITS +: VERTEX_W];
	assign rd_w  = edge_rdata[WEIGHT_BITS-1:0];
	assign key_w = key_q[WEIGHT_BITS-1:0];

	logic [CW-1:0] jm1, ip1;
	logic          init_last, emit_go;

	assign jm1       = j_q - 1'b1;
	assign ip1       = i_q + 1'b1;
	assign init_last = (init_q == (VAW+1)'(MAX_VERTICES - 1));
	assign emit_go   = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && last_edge) begin
					state_d = S_INIT;
				end
			end
			S_INIT: begin
				if (init_last) begin
					if (cnt_q == '0) begin
						state_d = S_EMIT;
					end else if (cnt_q == CW'(1)) begin
						state_d = S_KE_RD;
					end else begin
						state_d = S_SK_RD;
					end
				end
			end
			S_SK_RD:  state_d = S_SK_CAP;
			S_SK_CAP: state_d = S_SJ_RD;
			S_SJ_RD:  state_d = S_SJ_CMP;
			S_SJ_CMP: begin
				if (rd_w > key_w) begin
					state_d = (jm1 == '0) ? S_SJ_PUT : S_SJ_RD;
				end else begin
					state_d = (ip1 == cnt_q) ? S_KE_RD : S_SK_RD;
				end
			end
			S_SJ_PUT: state_d = (ip1 == cnt_q) ? S_KE_RD : S_SK_RD;
			S_KE_RD:  state_d = S_KE_CAP;
			S_KE_CAP: state_d = S_FR_RD;
			S_FR_RD:  state_d = S_FR_CHK;
			S_FR_CHK: state_d = (par_rdata == r_q) ? S_FC_RD : S_FR_RD;
			S_FC_RD:  state_d = S_FC_CHK;
			S_FC_CHK: begin
				if (par_rdata != r_q) begin
					state_d = S_FC_RD;
				end else if (!which_q) begin
					state_d = S_FR_RD;
				end else if (ra_q != r_q) begin
					state_d = S_RK_A;
				end else begin
					state_d = (ip1 == cnt_q) ? S_EMIT : S_KE_RD;
				end
			end
			S_RK_A:   state_d = S_RK_B;
			S_RK_B:   state_d = S_LINK;
			S_LINK:   state_d = (ip1 == cnt_q) ? S_EMIT : S_KE_RD;
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_stall   = (state_q != S_IDLE);
		edge_we    = 1'b0;
		edge_waddr = cnt_q[EAW-1:0];
		edge_wdata = {vertex_a, vertex_b, w_in};
		edge_re    = 1'b0;
		edge_raddr = i_q[EAW-1:0];
		par_we     = 1'b0;
		par_waddr  = init_q[VAW-1:0];
		par_wdata  = init_q[VAW-1:0];
		par_re     = 1'b0;
		par_raddr  = r_q;
		rank_we    = 1'b0;
		rank_waddr = init_q[VAW-1:0];
		rank_wdata = '0;
		rank_re    = 1'b0;
		rank_raddr = ra_q;
		unique case (state_q)
			S_IDLE: begin
				edge_we = in_xfer && edge_ok;
			end
			S_INIT: begin
				par_we  = 1'b1;
				rank_we = 1'b1;
			end
			S_SK_RD, S_KE_RD: begin
				edge_re = 1'b1;
			end
			S_SJ_RD: begin
				edge_re    = 1'b1;
				edge_raddr = jm1[EAW-1:0];
			end
			S_SJ_CMP: begin
				edge_we    = 1'b1;
				edge_waddr = j_q[EAW-1:0];
				edge_wdata = (rd_w > key_w) ? edge_rdata : key_q;
			end
			S_SJ_PUT: begin
				edge_we    = 1'b1;
				edge_waddr = '0;
				edge_wdata = key_q;
			end
			S_FR_RD: begin
				par_re = 1'b1;
			end
			S_FC_RD: begin
				par_re    = 1'b1;
				par_raddr = v_q;
			end
			S_FC_CHK: begin
				// path compression: point this node straight at the root
				par_we    = (par_rdata != r_q);
				par_waddr = v_q;
				par_wdata = r_q;
			end
			S_RK_A: begin
				rank_re = 1'b1;
			end
			S_RK_B: begin
				rank_re    = 1'b1;
				rank_raddr = eb_q;
			end
			S_LINK: begin
				par_we = 1'b1;
				if (rank_a_q < rank_rdata) begin
					par_waddr = ra_q;
					par_wdata = eb_q;
				end else begin
					par_waddr = eb_q;
					par_wdata = ra_q;
				end
				rank_waddr = ra_q;
				rank_wdata = rank_a_q + 1'b1;
				rank_we    = (rank_a_q == rank_rdata) && (rank_a_q != RANK_MAX);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			total_q     <= '0;
			tree_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && in_xfer && edge_ok) begin
				cnt_q   <= cnt_q + 1'b1;
				total_q <= sat_add(total_q, 32'(w_in));
			end
			if (state_q == S_LINK) begin
				tree_q <= sat_add(tree_q, 32'(w_q));
			end
			if (state_q == S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				total_q     <= '0;
				tree_q      <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				init_q <= '0;
			end
			S_INIT: begin
				init_q <= init_q + 1'b1;
				i_q    <= (cnt_q > CW'(1)) ? CW'(1) : '0;
			end
			S_SK_CAP: begin
				key_q <= edge_rdata;
				j_q   <= i_q;
			end
			S_SJ_CMP: begin
				if (rd_w > key_w) begin
					j_q <= jm1;
				end else begin
					i_q <= (ip1 == cnt_q) ? '0 : ip1;
				end
			end
			S_SJ_PUT: begin
				i_q <= (ip1 == cnt_q) ? '0 : ip1;
			end
			S_KE_CAP: begin
				r_q     <= vtx_addr(rd_a);
				v_q     <= vtx_addr(rd_a);
				eb_q    <= vtx_addr(rd_b);
				w_q     <= rd_w;
				which_q <= 1'b0;
			end
			S_FR_CHK: begin
				if (par_rdata != r_q) begin
					r_q <= par_rdata;
				end
			end
			S_FC_CHK: begin
				if (par_rdata != r_q) begin
					v_q <= par_rdata;
				end else if (!which_q) begin
					ra_q    <= r_q;
					r_q     <= eb_q;
					v_q     <= eb_q;
					which_q <= 1'b1;
				end else begin
					// eb_q now holds the root of the second endpoint
					eb_q <= r_q;
					if (ra_q == r_q) begin
						i_q <= ip1;
					end
				end
			end
			S_RK_B: begin
				rank_a_q <= rank_rdata;
			end
			S_LINK: begin
				i_q <= ip1;
			end
			S_EMIT: begin
				if (emit_go) begin
					forest_q    <= tree_q;
					total_out_q <= total_q;
					savings_q   <= (tree_q <= total_q) ? total_q - tree_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign savings       = savings_q;
	assign forest_weight = forest_q;
	assign total_weight  = total_out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_EDGES))
		else $error("edge count above store depth");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		(edge_we && state_q == S_IDLE) |-> (cnt_q < CW'(MAX_EDGES)))
		else $error("edge written with store full");

	a_par_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(par_we && par_re))
		else $error("parent memory read and written in one cycle");

	a_sum_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (forest_weight > total_weight)
			|| ({1'b0, savings} + {1'b0, forest_weight} == {1'b0, total_weight}))
		else $error("savings inconsistent with sums");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_go) |=> (cnt_q == '0 && out_valid_q))
		else $error("state not cleared after result");
`endif

endmodule
`default_nettype wire
